// ===== rtl/als_pkg.sv =====
// Shared types, codes and constants of the ambient light sensor sequencer.
// No dependencies; every other file of the block imports this package.
package als_pkg;

    localparam int FUNC_W  = 2;
    localparam int MODE_W  = 8;
    localparam int TIME_W  = 32;
    localparam int RAW_W   = 16;
    localparam int CODE_W  = 2;
    localparam int LUX_W   = 21;
    localparam int PHASE_W = 2;
    localparam int MTIME_W = 16;
    localparam int RETRY_W = 8;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 16;

    // Item selectors.
    localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FETCH = 2'd2;

    // Phases of the measurement sequence.
    localparam logic [PHASE_W-1:0] PH_READY   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_STARTED = 2'd1;
    localparam logic [PHASE_W-1:0] PH_READ    = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DONE    = 2'd3;

    // Result codes.
    localparam logic [CODE_W-1:0] RC_OK      = 2'd0;
    localparam logic [CODE_W-1:0] RC_BUS_ERR = 2'd1;
    localparam logic [CODE_W-1:0] RC_NO_DATA = 2'd2;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_MEASURE_TIME = 2'd0;
    localparam logic [CIDX_W-1:0] REG_MAX_RETRIES  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_DEFAULT_MODE = 2'd2;

    // Register reset values.
    localparam logic [MTIME_W-1:0] MEASURE_TIME_RST = 16'd180;
    localparam logic [RETRY_W-1:0] MAX_RETRIES_RST  = 8'd3;
    localparam logic [MODE_W-1:0]  DEFAULT_MODE_RST = 8'h10;

    // Sensor mode command bytes.
    localparam logic [MODE_W-1:0] MODE_CONT_H1 = 8'h10;
    localparam logic [MODE_W-1:0] MODE_CONT_H2 = 8'h11;
    localparam logic [MODE_W-1:0] MODE_CONT_L  = 8'h13;
    localparam logic [MODE_W-1:0] MODE_ONCE_L  = 8'h23;

    // Conversion: 1/16 lx = raw*40/3 (high res) or raw*80/3 (low res).
    localparam int SCALED_W = 23;
    localparam int RECIP_W  = 24;
    localparam int RECIP_SH = 25;
    localparam logic [RECIP_W-1:0] RECIP_3 = 24'hAAAAAB;
    localparam logic [LUX_W-1:0]   LUX_LIMIT_Q4 = 21'd1600000;

    typedef struct packed {
        logic                send_command;
        logic [MODE_W-1:0]   command_byte;
        logic                read_request;
        logic [CODE_W-1:0]   result_code;
        logic [LUX_W-1:0]    illuminance_lux_q4;
        logic                data_ready;
        logic [PHASE_W-1:0]  phase;
    } als_result_t;

    function automatic logic is_low_res(input logic [MODE_W-1:0] m);
        return (m == MODE_CONT_L) || (m == MODE_ONCE_L);
    endfunction

    function automatic logic is_continuous(input logic [MODE_W-1:0] m);
        return (m == MODE_CONT_H1) || (m == MODE_CONT_H2) || (m == MODE_CONT_L);
    endfunction

endpackage

// ===== rtl/als_if.sv =====
// Channel interfaces of the ambient light sensor sequencer: step items,
// result items and configuration writes. Depends on als_pkg.
interface als_step_if;
    import als_pkg::*;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [MODE_W-1:0]   new_mode;
    logic [TIME_W-1:0]   now_ms;
    logic                bus_ok;
    logic [RAW_W-1:0]    read_word;

    modport source (output valid, func, new_mode, now_ms, bus_ok, read_word,
                    input ready);
    modport sink   (input valid, func, new_mode, now_ms, bus_ok, read_word,
                    output ready);
endinterface

interface als_result_if;
    import als_pkg::*;
    logic                valid;
    logic                ready;
    logic                send_command;
    logic [MODE_W-1:0]   command_byte;
    logic                read_request;
    logic [CODE_W-1:0]   result_code;
    logic [LUX_W-1:0]    illuminance_lux_q4;
    logic                data_ready;
    logic [PHASE_W-1:0]  phase;

    modport source (output valid, send_command, command_byte, read_request,
                    result_code, illuminance_lux_q4, data_ready, phase,
                    input ready);
    modport sink   (input valid, send_command, command_byte, read_request,
                    result_code, illuminance_lux_q4, data_ready, phase,
                    output ready);
endinterface

interface als_cfg_if;
    import als_pkg::*;
    logic                valid;
    logic                ready;
    logic [CIDX_W-1:0]   index;
    logic [CDATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ambient_light_sensor_sequencer_top.sv =====
// Top level of the ambient light sensor measurement sequencer.
// Depends on als_pkg and the channel interfaces in als_if.sv.
//
// Usage: each step beat is a run step of the phase machine, a mode change
// or a fetch of the latest reading, together with the millisecond time and
// the outcome of the bus transfer made in that step. Every step beat yields
// exactly one result beat with the transfer to issue, a result code, the
// illuminance in 1/16 lux, the ready flag and the phase after the step.
// The cfg channel writes measure time (index 0), retry limit (index 1) and
// the reset mode byte (index 2); it is always ready. The reset mode byte
// only takes effect through reset, which loads its reset value into the
// current mode, so a later write to it changes nothing that is observable.
//
// Pipeline: an accepted step beat is captured in the input register and
// then processed into the result register, which offers its result beat.
// Throughput: one beat per cycle while the receiver takes each result;
// the state update and the lux conversion (a shift-add, one constant
// multiplier and a compare) are combinational between the two registers.
// When the receiver stalls the result register holds its beat, the input
// register fills, and step.ready drops until the result is taken.
// Reset clears all state, returns the phase to ready and empties both
// pipeline registers; configuration returns to its reset values.
module ambient_light_sensor_sequencer_top
(
    input  logic                  clk,
    input  logic                  rst_n,
    als_cfg_if.sink               cfg,
    als_step_if.sink              step,
    als_result_if.source          result
);
    import als_pkg::*;

    // Configuration registers.
    logic [MTIME_W-1:0]  measure_time_reg;
    logic [RETRY_W-1:0]  max_retries_reg;

    // Input register.
    logic                s1_valid_reg;
    logic [FUNC_W-1:0]   s1_func_reg;
    logic [MODE_W-1:0]   s1_mode_reg;
    logic [TIME_W-1:0]   s1_now_reg;
    logic                s1_ok_reg;
    logic [RAW_W-1:0]    s1_raw_reg;

    // Sequencer state.
    logic [PHASE_W-1:0]  phase_reg,  phase_next;
    logic [MODE_W-1:0]   mode_reg,   mode_next;
    logic [TIME_W-1:0]   stamp_reg,  stamp_next;
    logic [RETRY_W-1:0]  retry_reg,  retry_next;
    logic                rdy_reg,    rdy_next;
    logic [LUX_W-1:0]    lux_reg,    lux_next;

    // Result register.
    logic                out_valid_reg, out_valid_next;
    als_result_t         out_reg,       out_next;

    logic                advance;
    logic [TIME_W-1:0]   elapsed;
    logic [SCALED_W-1:0] scaled40;
    logic [SCALED_W-1:0] scaled;
    logic [SCALED_W+RECIP_W-1:0] product;
    logic [LUX_W-1:0]    lux_conv;
    logic                over_range;

    // The input register moves on whenever the result register is free or
    // is being emptied in this cycle.
    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign step.ready = !s1_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            measure_time_reg <= MEASURE_TIME_RST;
            max_retries_reg  <= MAX_RETRIES_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MEASURE_TIME: measure_time_reg <= cfg.data;
                REG_MAX_RETRIES:  max_retries_reg  <= cfg.data[RETRY_W-1:0];
                default:
                begin
                    // The reset mode byte and unused indexes need no storage.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (step.ready)
        begin
            s1_valid_reg <= step.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.valid && step.ready)
        begin
            s1_func_reg <= step.func;
            s1_mode_reg <= step.new_mode;
            s1_now_reg  <= step.now_ms;
            s1_ok_reg   <= step.bus_ok;
            s1_raw_reg  <= step.read_word;
        end
    end

    // Lux conversion: raw*40 (or *80) by shift-add, then a floored divide by
    // three through a multiply with the rounded-up reciprocal, exact for all
    // 23-bit dividends.
    assign elapsed  = s1_now_reg - stamp_reg;
    assign scaled40 = ({7'd0, s1_raw_reg} << 5) + ({7'd0, s1_raw_reg} << 3);
    assign scaled   = is_low_res(mode_reg) ? (scaled40 << 1) : scaled40;
    assign product  = scaled * RECIP_3;
    assign lux_conv = product[RECIP_SH +: LUX_W];
    assign over_range = lux_conv > LUX_LIMIT_Q4;

    always_comb
    begin
        phase_next = phase_reg;
        mode_next  = mode_reg;
        stamp_next = stamp_reg;
        retry_next = retry_reg;
        rdy_next   = rdy_reg;
        lux_next   = lux_reg;
        out_next   = '0;

        unique case (s1_func_reg)
            FUNC_RUN:
            begin
                if (retry_reg >= max_retries_reg)
                begin
                    // Retry limit reached: give up and drop back to ready.
                    phase_next = PH_READY;
                    retry_next = '0;
                    rdy_next   = 1'b0;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_READY:
                        begin
                            out_next.send_command = 1'b1;
                            out_next.command_byte = mode_reg;
                            if (s1_ok_reg)
                            begin
                                phase_next = PH_STARTED;
                                stamp_next = s1_now_reg;
                                retry_next = '0;
                            end
                            else
                            begin
                                retry_next = retry_reg + 1'b1;
                            end
                        end
                        PH_STARTED:
                        begin
                            if (elapsed >= {16'd0, measure_time_reg})
                            begin
                                phase_next = PH_READ;
                            end
                        end
                        PH_READ:
                        begin
                            out_next.read_request = 1'b1;
                            if (s1_ok_reg)
                            begin
                                lux_next = lux_conv;
                                // An over-range reading is kept but not
                                // flagged, and the next run step reads again.
                                rdy_next = !over_range;
                                if (!over_range)
                                begin
                                    phase_next = PH_DONE;
                                    retry_next = '0;
                                end
                            end
                            else
                            begin
                                retry_next = retry_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            // Complete: once the reading has been fetched,
                            // continuous modes restart the wait, other modes return to ready.
                            if (!rdy_reg)
                            begin
                                if (is_continuous(mode_reg))
                                begin
                                    phase_next = PH_STARTED;
                                    stamp_next = s1_now_reg;
                                end
                                else
                                begin
                                    phase_next = PH_READY;
                                end
                            end
                        end
                    endcase
                end
            end
            FUNC_SET:
            begin
                out_next.send_command = 1'b1;
                out_next.command_byte = s1_mode_reg;
                if (!s1_ok_reg)
                begin
                    phase_next           = PH_READY;
                    out_next.result_code = RC_BUS_ERR;
                end
                else
                begin
                    mode_next  = s1_mode_reg;
                    phase_next = PH_STARTED;
                    stamp_next = s1_now_reg;
                    rdy_next   = 1'b0;
                    retry_next = '0;
                end
            end
            FUNC_FETCH:
            begin
                if (!rdy_reg)
                begin
                    out_next.result_code = RC_NO_DATA;
                end
                else
                begin
                    out_next.illuminance_lux_q4 = lux_reg;
                    rdy_next                    = 1'b0;
                end
            end
            default:
            begin
                // Unused selector: no change, status only.
            end
        endcase

        out_next.data_ready = rdy_next;
        out_next.phase      = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_READY;
            mode_reg  <= DEFAULT_MODE_RST;
            stamp_reg <= '0;
            retry_reg <= '0;
            rdy_reg   <= 1'b0;
            lux_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
            stamp_reg <= stamp_next;
            retry_reg <= retry_next;
            rdy_reg   <= rdy_next;
            lux_reg   <= lux_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.send_command       = out_reg.send_command;
    assign result.command_byte       = out_reg.command_byte;
    assign result.read_request       = out_reg.read_request;
    assign result.result_code        = out_reg.result_code;
    assign result.illuminance_lux_q4 = out_reg.illuminance_lux_q4;
    assign result.data_ready         = out_reg.data_ready;
    assign result.phase              = out_reg.phase;

endmodule

// ===== rtl/als_checker.sv =====
// Port-level assertions for the ambient light sensor sequencer and the bind
// that attaches them to the top level. Depends on als_pkg.
module als_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          valid,
    input logic                          ready,
    input logic                          send_command,
    input logic [als_pkg::MODE_W-1:0]    command_byte,
    input logic                          read_request,
    input logic [als_pkg::CODE_W-1:0]    result_code,
    input logic [als_pkg::LUX_W-1:0]     illuminance_lux_q4,
    input logic                          data_ready,
    input logic [als_pkg::PHASE_W-1:0]   phase
);
    import als_pkg::*;

    // A stalled result beat stays valid and keeps its command byte, phase and reading.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(command_byte) && $stable(phase)
            && $stable(illuminance_lux_q4))
        else $error("result beat changed while stalled");

    // Without a command write the command byte reads zero.
    a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !send_command |-> command_byte == '0)
        else $error("command byte set without a command write");

    // A delivered reading always consumes the ready flag.
    a_fetch_clears: assert property (@(posedge clk) disable iff (!rst_n)
        valid && illuminance_lux_q4 != '0 |-> !data_ready && result_code == RC_OK)
        else $error("reading delivered but ready flag still set");

    // A failed mode change wrote its command and fell back to ready.
    a_bus_err: assert property (@(posedge clk) disable iff (!rst_n)
        valid && result_code == RC_BUS_ERR |-> send_command && phase == PH_READY)
        else $error("bus error reported without fallback to ready");

    // A step never writes a command and reads in the same beat.
    a_one_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        valid && read_request |-> !send_command)
        else $error("command write and read in one step");

endmodule

bind ambient_light_sensor_sequencer_top als_checker u_als_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .valid              (result.valid),
    .ready              (result.ready),
    .send_command       (result.send_command),
    .command_byte       (result.command_byte),
    .read_request       (result.read_request),
    .result_code        (result.result_code),
    .illuminance_lux_q4 (result.illuminance_lux_q4),
    .data_ready         (result.data_ready),
    .phase              (result.phase)
);
